FILE: rtl/core/fgie_pkg.sv
`default_nettype none

package fgie_pkg;

    localparam int SLOTS_DEFAULT = 16;
    localparam int FLAG_W        = 32;
    localparam int ACT_W         = 29;
    localparam int GROUPS        = 5;

    typedef enum logic [1:0] {
        CMD_SET   = 2'd0,
        CMD_CLR   = 2'd1,
        CMD_SEND  = 2'd2,
        CMD_CLEAR = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_MOD  = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    localparam logic [GROUPS-1:0] GRP_F0_F4   = 5'b00001;
    localparam logic [GROUPS-1:0] GRP_F5_F8   = 5'b00010;
    localparam logic [GROUPS-1:0] GRP_F9_F12  = 5'b00100;
    localparam logic [GROUPS-1:0] GRP_F13_F20 = 5'b01000;
    localparam logic [GROUPS-1:0] GRP_F21_F28 = 5'b10000;

    localparam logic [3:0] PFX_F5_F8   = 4'b1011;
    localparam logic [3:0] PFX_F9_F12  = 4'b1010;
    localparam logic [2:0] PFX_F0_F4   = 3'b100;
    localparam logic [7:0] INS_F13_F20 = 8'd222;
    localparam logic [7:0] INS_F21_F28 = 8'd223;

    typedef struct packed {
        logic [7:0] ins;
        logic [7:0] data;
        logic       has;
    } enc_t;

    function automatic logic [GROUPS-1:0] changed_groups(input logic [FLAG_W-1:0] chg);
        logic [GROUPS-1:0] g;
        g[0] = |chg[4:0];
        g[1] = |chg[8:5];
        g[2] = |chg[12:9];
        g[3] = |chg[20:13];
        g[4] = |chg[28:21];
        return g;
    endfunction

    function automatic enc_t encode_group(input logic [GROUPS-1:0] sel,
                                          input logic [ACT_W-1:0] act);
        enc_t e;
        e = '0;
        case (sel)
            GRP_F0_F4: begin
                e.ins = {PFX_F0_F4, act[0], act[4:1]};
            end
            GRP_F5_F8: begin
                e.ins = {PFX_F5_F8, act[8:5]};
            end
            GRP_F9_F12: begin
                e.ins = {PFX_F9_F12, act[12:9]};
            end
            GRP_F13_F20: begin
                e.ins  = INS_F13_F20;
                e.data = act[20:13];
                e.has  = 1'b1;
            end
            GRP_F21_F28: begin
                e.ins  = INS_F21_F28;
                e.data = act[28:21];
                e.has  = 1'b1;
            end
            default: begin
                e = '0;
            end
        endcase
        return e;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/fgie_ram.sv
`default_nettype none

module fgie_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rd_data_reg <= mem_reg[raddr];
    end

    assign rdata = rd_data_reg;

endmodule

`default_nettype wire

FILE: rtl/core/function_group_instruction_encoder_top.sv
// Set, clear and clear-slot commands pass through a slot read and a write back.
// A send reads the slot, writes it back, then emits one instruction per cycle while
// m_ready is high. Commands are taken one at a time: a new command is accepted only
// when idle, after the read-modify-write of the flag RAMs and the last instruction.
// Reset: synchronous active-low aresetn clears the controller and the per-slot
// valid bits, so every slot reads as all flags clear; no clearing pass is needed.
`default_nettype none

module function_group_instruction_encoder_top #(
    parameter int SLOTS = fgie_pkg::SLOTS_DEFAULT
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_func,
    input  wire logic [3:0]  s_register_slot,
    input  wire logic [4:0]  s_function_number,
    input  wire logic [13:0] s_loco_address,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [3:0]       m_out_slot,
    output logic [13:0]      m_out_address,
    output logic [7:0]       m_instruction_byte,
    output logic [7:0]       m_data_byte,
    output logic             m_has_data_byte,
    output logic             m_last
);

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int FW = fgie_pkg::FLAG_W;
    localparam int GW = fgie_pkg::GROUPS;

    fgie_pkg::state_t          state_reg, state_next;
    fgie_pkg::cmd_t            cmd_reg, cmd_next;
    logic [3:0]                slot_reg, slot_next;
    logic [4:0]                fn_reg, fn_next;
    logic [13:0]               addr_reg, addr_next;
    logic [fgie_pkg::ACT_W-1:0] act_reg, act_next;
    logic [GW-1:0]             pending_reg, pending_next;
    logic [SLOTS-1:0]          valid_reg, valid_next;

    logic [7:0]    s_slot_ext;
    logic [7:0]    q_slot_ext;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic          slot_ok;
    logic          s_xfer;
    logic          m_xfer;
    logic          we;

    logic [FW-1:0] act_rdata, sent_rdata;
    logic [FW-1:0] act_cur, sent_cur;
    logic [FW-1:0] act_new, sent_new;
    logic [FW-1:0] bit_mask;
    logic [GW-1:0] groups;
    logic [GW-1:0] sel;
    logic [GW-1:0] rest;
    fgie_pkg::enc_t enc;

    assign s_slot_ext = {4'd0, s_register_slot};
    assign q_slot_ext = {4'd0, slot_reg};
    assign rd_addr    = s_slot_ext[AW-1:0];
    assign wr_addr    = q_slot_ext[AW-1:0];
    assign slot_ok    = {5'd0, s_register_slot} < 9'(SLOTS);

    assign s_ready = (state_reg == fgie_pkg::ST_IDLE);
    assign m_valid = (state_reg == fgie_pkg::ST_EMIT);
    assign s_xfer  = s_valid && s_ready;
    assign m_xfer  = m_valid && m_ready;
    assign we      = (state_reg == fgie_pkg::ST_MOD);

    fgie_ram #(.WIDTH(FW), .DEPTH(SLOTS)) u_active_ram (
        .clk   (aclk),
        .we    (we),
        .waddr (wr_addr),
        .wdata (act_new),
        .raddr (rd_addr),
        .rdata (act_rdata)
    );

    fgie_ram #(.WIDTH(FW), .DEPTH(SLOTS)) u_sent_ram (
        .clk   (aclk),
        .we    (we),
        .waddr (wr_addr),
        .wdata (sent_new),
        .raddr (rd_addr),
        .rdata (sent_rdata)
    );

    // unwritten slots read as all clear
    always_comb begin
        act_cur  = valid_reg[wr_addr] ? act_rdata  : '0;
        sent_cur = valid_reg[wr_addr] ? sent_rdata : '0;
        bit_mask = FW'(1) << fn_reg;
        case (cmd_reg)
            fgie_pkg::CMD_SET: begin
                act_new  = act_cur | bit_mask;
                sent_new = sent_cur;
            end
            fgie_pkg::CMD_CLR: begin
                act_new  = act_cur & ~bit_mask;
                sent_new = sent_cur;
            end
            fgie_pkg::CMD_SEND: begin
                act_new  = act_cur;
                sent_new = act_cur;
            end
            default: begin
                act_new  = '0;
                sent_new = '0;
            end
        endcase
        groups = fgie_pkg::changed_groups(act_cur ^ sent_cur);
    end

    // emit lowest pending group first
    always_comb begin
        sel = pending_reg & (~pending_reg + GW'(1));
        rest = pending_reg & ~sel;
        enc  = fgie_pkg::encode_group(sel, act_reg);
    end

    assign m_out_slot         = slot_reg;
    assign m_out_address      = addr_reg;
    assign m_instruction_byte = enc.ins;
    assign m_data_byte        = enc.data;
    assign m_has_data_byte    = enc.has;
    assign m_last             = (rest == '0);

    always_comb begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        slot_next    = slot_reg;
        fn_next      = fn_reg;
        addr_next    = addr_reg;
        act_next     = act_reg;
        pending_next = pending_reg;
        valid_next   = valid_reg;
        case (state_reg)
            fgie_pkg::ST_IDLE: begin
                if (s_xfer && slot_ok) begin
                    cmd_next   = fgie_pkg::cmd_t'(s_func);
                    slot_next  = s_register_slot;
                    fn_next    = s_function_number;
                    addr_next  = s_loco_address;
                    state_next = fgie_pkg::ST_MOD;
                end
            end
            fgie_pkg::ST_MOD: begin
                valid_next[wr_addr] = 1'b1;
                act_next = act_cur[fgie_pkg::ACT_W-1:0];
                if (cmd_reg == fgie_pkg::CMD_SEND && groups != '0) begin
                    pending_next = groups;
                    state_next   = fgie_pkg::ST_EMIT;
                end else begin
                    state_next   = fgie_pkg::ST_IDLE;
                end
            end
            fgie_pkg::ST_EMIT: begin
                if (m_xfer) begin
                    pending_next = rest;
                    if (rest == '0) begin
                        state_next = fgie_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = fgie_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= fgie_pkg::ST_IDLE;
            pending_reg <= '0;
            valid_reg   <= '0;
        end else begin
            state_reg   <= state_next;
            pending_reg <= pending_next;
            valid_reg   <= valid_next;
        end
        cmd_reg  <= cmd_next;
        slot_reg <= slot_next;
        fn_reg   <= fn_next;
        addr_reg <= addr_next;
        act_reg  <= act_next;
    end

endmodule

`default_nettype wire

FILE: rtl/core/fgie_checker.sv
`default_nettype none

module fgie_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [3:0]  m_out_slot,
    input wire logic [13:0] m_out_address,
    input wire logic [7:0]  m_instruction_byte,
    input wire logic [7:0]  m_data_byte,
    input wire logic        m_has_data_byte,
    input wire logic        m_last
);

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_instruction_byte)
            && $stable(m_data_byte) && $stable(m_last)
            && $stable(m_out_slot) && $stable(m_out_address))
        else $error("stalled transfer changed");

    a_no_take_while_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input taken while results pending");

    a_gap_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !m_valid)
        else $error("result without slot read");

    a_data_group: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_has_data_byte |->
            m_instruction_byte == fgie_pkg::INS_F13_F20
            || m_instruction_byte == fgie_pkg::INS_F21_F28)
        else $error("data byte on single-byte group");

endmodule

bind function_group_instruction_encoder_top fgie_checker u_fgie_checker (
    .aclk               (aclk),
    .aresetn            (aresetn),
    .s_valid            (s_valid),
    .s_ready            (s_ready),
    .m_valid            (m_valid),
    .m_ready            (m_ready),
    .m_out_slot         (m_out_slot),
    .m_out_address      (m_out_address),
    .m_instruction_byte (m_instruction_byte),
    .m_data_byte        (m_data_byte),
    .m_has_data_byte    (m_has_data_byte),
    .m_last             (m_last)
);

`default_nettype wire

FILE: tb/sv/tb_function_group_instruction_encoder_top.sv
`default_nettype none

module tb_function_group_instruction_encoder_top;
    import fgie_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int ITEMS_PER_PHASE = 80;

    typedef struct packed {
        logic [3:0]  slot;
        logic [13:0] addr;
        logic [7:0]  ins;
        logic [7:0]  data;
        logic        has;
        logic        last;
    } instr_t;

    typedef struct packed {
        cmd_t        cmd;
        logic [3:0]  slot;
        logic [4:0]  fnum;
        logic [13:0] addr;
        logic        typed;
        logic        one;
        logic [7:0]  ins;
        logic [7:0]  data;
        logic        has;
    } row_t;

    localparam row_t DIRECTED [24] = '{
        '{CMD_SEND,  4'd0,  5'd0,  14'd0,     1'b1, 1'b0, 8'd0,   8'd0,   1'b0},
        '{CMD_SET,   4'd0,  5'd0,  14'd0,     1'b1, 1'b0, 8'd0,   8'd0,   1'b0},
        '{CMD_SEND,  4'd0,  5'd31, 14'd10239, 1'b1, 1'b1, 8'd144, 8'd0,   1'b0},
        '{CMD_SET,   4'd15, 5'd28, 14'd0,     1'b1, 1'b0, 8'd0,   8'd0,   1'b0},
        '{CMD_SEND,  4'd15, 5'd0,  14'd0,     1'b1, 1'b1, 8'd223, 8'h80,  1'b1},
        '{CMD_SET,   4'd15, 5'd31, 14'd5,     1'b1, 1'b0, 8'd0,   8'd0,   1'b0},
        '{CMD_SET,   4'd15, 5'd29, 14'd5,     1'b1, 1'b0, 8'd0,   8'd0,   1'b0},
        '{CMD_SEND,  4'd15, 5'd0,  14'd5,     1'b1, 1'b0, 8'd0,   8'd0,   1'b0},
        '{CMD_SET,   4'd3,  5'd1,  14'd0,     1'b0, 1'b0, 8'd0,   8'd0,   1'b0},
        '{CMD_SET,   4'd3,  5'd4,  14'd0,     1'b0, 1'b0, 8'd0,   8'd0,   1'b0},
        '{CMD_SET,   4'd3,  5'd5,  14'd0,     1'b0, 1'b0, 8'd0,   8'd0,   1'b0},
        '{CMD_SET,   4'd3,  5'd12, 14'd0,     1'b0, 1'b0, 8'd0,   8'd0,   1'b0},
        '{CMD_SET,   4'd3,  5'd13, 14'd0,     1'b0, 1'b0, 8'd0,   8'd0,   1'b0},
        '{CMD_SET,   4'd3,  5'd20, 14'd0,     1'b0, 1'b0, 8'd0,   8'd0,   1'b0},
        '{CMD_SET,   4'd3,  5'd21, 14'd0,     1'b0, 1'b0, 8'd0,   8'd0,   1'b0},
        '{CMD_SEND,  4'd3,  5'd0,  14'd8191,  1'b0, 1'b0, 8'd0,   8'd0,   1'b0},
        '{CMD_CLR,   4'd3,  5'd20, 14'd0,     1'b0, 1'b0, 8'd0,   8'd0,   1'b0},
        '{CMD_SEND,  4'd3,  5'd0,  14'd6144,  1'b0, 1'b0, 8'd0,   8'd0,   1'b0},
        '{CMD_SET,   4'd3,  5'd9,  14'd0,     1'b1, 1'b0, 8'd0,   8'd0,   1'b0},
        '{CMD_CLEAR, 4'd3,  5'd0,  14'd0,     1'b1, 1'b0, 8'd0,   8'd0,   1'b0},
        '{CMD_SEND,  4'd3,  5'd0,  14'd1,     1'b1, 1'b0, 8'd0,   8'd0,   1'b0},
        '{CMD_SET,   4'd7,  5'd30, 14'd0,     1'b1, 1'b0, 8'd0,   8'd0,   1'b0},
        '{CMD_CLR,   4'd7,  5'd30, 14'd0,     1'b1, 1'b0, 8'd0,   8'd0,   1'b0},
        '{CMD_SEND,  4'd7,  5'd0,  14'd2047,  1'b1, 1'b0, 8'd0,   8'd0,   1'b0}
    };

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_func = '0;
    logic [3:0]  s_register_slot = '0;
    logic [4:0]  s_function_number = '0;
    logic [13:0] s_loco_address = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [3:0]  m_out_slot;
    logic [13:0] m_out_address;
    logic [7:0]  m_instruction_byte;
    logic [7:0]  m_data_byte;
    logic        m_has_data_byte;
    logic        m_last;

    logic [31:0] active_fl [16];
    logic [31:0] sent_fl [16];
    instr_t      expected_instr_q [$];
    int          errors = 0;
    int          cycle_cnt = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;

    function_group_instruction_encoder_top u_top (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_func            (s_func),
        .s_register_slot   (s_register_slot),
        .s_function_number (s_function_number),
        .s_loco_address    (s_loco_address),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_out_slot        (m_out_slot),
        .m_out_address     (m_out_address),
        .m_instruction_byte(m_instruction_byte),
        .m_data_byte       (m_data_byte),
        .m_has_data_byte   (m_has_data_byte),
        .m_last            (m_last)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("function_group_instruction_encoder_top test failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        instr_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_instr_q.size() == 0) begin
                $error("unexpected instruction: slot %0d ins %0d", m_out_slot,
                       m_instruction_byte);
                errors++;
            end else begin
                e = expected_instr_q.pop_front();
                if (m_out_slot !== e.slot) begin
                    $error("out_slot: expected %0d, got %0d", e.slot, m_out_slot);
                    errors++;
                end
                if (m_out_address !== e.addr) begin
                    $error("out_address: expected %0d, got %0d", e.addr, m_out_address);
                    errors++;
                end
                if (m_instruction_byte !== e.ins) begin
                    $error("instruction_byte: expected %0d, got %0d", e.ins,
                           m_instruction_byte);
                    errors++;
                end
                if (m_data_byte !== e.data) begin
                    $error("data_byte: expected %0d, got %0d", e.data, m_data_byte);
                    errors++;
                end
                if (m_has_data_byte !== e.has) begin
                    $error("has_data_byte: expected %0d, got %0d", e.has, m_has_data_byte);
                    errors++;
                end
                if (m_last !== e.last) begin
                    $error("last: expected %0d, got %0d", e.last, m_last);
                    errors++;
                end
            end
        end
    end

    function automatic void encode_command(input cmd_t c, input logic [3:0] sl,
                                           input logic [4:0] fn, input logic [13:0] ad,
                                           ref instr_t res [$]);
        logic [31:0] act;
        logic [31:0] chg;
        res = {};
        case (c)
            CMD_SET: begin
                active_fl[sl][fn] = 1'b1;
            end
            CMD_CLR: begin
                active_fl[sl][fn] = 1'b0;
            end
            CMD_CLEAR: begin
                active_fl[sl] = '0;
                sent_fl[sl]   = '0;
            end
            default: begin
                act = active_fl[sl];
                chg = act ^ sent_fl[sl];
                if (|chg[4:0])
                    res.push_back('{sl, ad, 8'd128 + {3'b000, act[0], act[4:1]},
                                    8'd0, 1'b0, 1'b0});
                if (|chg[8:5])
                    res.push_back('{sl, ad, 8'd176 + {4'b0000, act[8:5]}, 8'd0, 1'b0, 1'b0});
                if (|chg[12:9])
                    res.push_back('{sl, ad, 8'd160 + {4'b0000, act[12:9]}, 8'd0, 1'b0, 1'b0});
                if (|chg[20:13])
                    res.push_back('{sl, ad, 8'd222, act[20:13], 1'b1, 1'b0});
                if (|chg[28:21])
                    res.push_back('{sl, ad, 8'd223, act[28:21], 1'b1, 1'b0});
                if (res.size() > 0)
                    res[res.size() - 1].last = 1'b1;
                sent_fl[sl] = act;
            end
        endcase
    endfunction

    function automatic logic [13:0] pick_address();
        if ($urandom_range(7) == 0)
            return ($urandom_range(1) == 1) ? 14'd10239 : 14'd0;
        return 14'($urandom_range(10239));
    endfunction

    task automatic drive_item(input cmd_t c, input logic [3:0] sl, input logic [4:0] fn,
                              input logic [13:0] ad, input logic typed, input logic one,
                              input instr_t typed_instr);
        instr_t res [$];
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid           <= 1'b1;
        s_func            <= c;
        s_register_slot   <= sl;
        s_function_number <= fn;
        s_loco_address    <= ad;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        encode_command(c, sl, fn, ad, res);
        if (typed) begin
            if (one)
                expected_instr_q.push_back(typed_instr);
        end else begin
            foreach (res[i]) expected_instr_q.push_back(res[i]);
        end
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_instr_q.size() != 0) @(posedge aclk);
    endtask

    initial begin
        row_t        r;
        logic [3:0]  sl;
        int          burst;
        int          cnt;
        cmd_t        c;
        foreach (active_fl[i]) begin
            active_fl[i] = '0;
            sent_fl[i]   = '0;
        end
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (DIRECTED[i]) begin
            r = DIRECTED[i];
            drive_item(r.cmd, r.slot, r.fnum, r.addr, r.typed, r.one,
                       '{r.slot, r.addr, r.ins, r.data, r.has, 1'b1});
        end
        drain_results();

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1) ? 84 : (ph == 3) ? 14 : 0;
            recv_stall_pct = (ph == 2) ? 84 : (ph == 3) ? 14 : 0;
            cnt = 0;
            while (cnt < ITEMS_PER_PHASE) begin
                sl = 4'($urandom_range(15));
                if ($urandom_range(9) < 8) begin
                    burst = $urandom_range(1, 5);
                    repeat (burst) begin
                        c = ($urandom_range(3) == 0) ? CMD_CLR : CMD_SET;
                        drive_item(c, sl, 5'($urandom_range(31)), pick_address(),
                                   1'b0, 1'b0, '0);
                    end
                    drive_item(CMD_SEND, sl, 5'($urandom_range(31)), pick_address(),
                               1'b0, 1'b0, '0);
                    cnt += burst + 1;
                end else begin
                    c = cmd_t'(2'($urandom_range(3)));
                    drive_item(c, sl, 5'($urandom_range(31)), pick_address(),
                               1'b0, 1'b0, '0);
                    cnt++;
                end
            end
            drain_results();
        end

        repeat (20) @(posedge aclk);
        if (errors == 0) begin
            $display("function_group_instruction_encoder_top test passed");
        end else begin
            $display("function_group_instruction_encoder_top test failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
